[rtl/core/brf_pkg.sv]
// shared widths, defaults and codes for the byte ring fifo
package brf_pkg;

    localparam int DEPTH_DEF   = 1024;
    localparam int MAX_RUN_DEF = 64;

    localparam int MODE_W = 3;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int OFF_W  = 10;
    localparam int HELD_W = 11;
    localparam int STAT_W = 2;

    typedef logic [MODE_W-1:0] mode_t;
    typedef logic [STAT_W-1:0] stat_t;

    localparam mode_t MODE_WRITE  = 3'd0;
    localparam mode_t MODE_READ   = 3'd1;
    localparam mode_t MODE_PEEK   = 3'd2;
    localparam mode_t MODE_FLUSH  = 3'd3;
    localparam mode_t MODE_STATUS = 3'd4;

    localparam stat_t STAT_OK        = 2'd0;
    localparam stat_t STAT_OVERFLOW  = 2'd1;
    localparam stat_t STAT_NOT_ENOUGH = 2'd2;
    localparam stat_t STAT_PEEK_RANGE = 2'd3;

endpackage

[rtl/core/brf_ram.sv]
// generic single-write, single-read ram with registered read data
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/byte_ring_fifo_with_peek.sv]
// circular byte fifo with run read, peek, flush and status query
//
// input channel (in_valid / in_ready) takes one command beat: mode selects
// write byte, read run, peek run, flush or status query. output channel
// (out_valid / out_ready) gives result beats of out_byte, status, held_count
// and last; last marks the final beat of a command.
// a command is taken only while the sequencer is idle. write, flush, status
// and any rejected or empty read or peek are accepted, then decided and
// loaded into the output register. a read or peek run is accepted and
// decided, then gives each byte by one read of the ring ram, whose registered
// read data is moved to the output register once that register is free.
// the output register parts the two sides: a new command is accepted while
// the last result beat still waits. when the receiver stalls, the sequencer
// holds at its next result until the output register frees up; nothing is
// dropped.
// reset empties the fifo (pointers and count to zero) and clears the output
// valid flag; ram contents are not cleared and bytes never written are never
// returned.
module byte_ring_fifo_with_peek #(
    parameter int DEPTH   = brf_pkg::DEPTH_DEF,
    parameter int MAX_RUN = brf_pkg::MAX_RUN_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [brf_pkg::MODE_W-1:0]  mode,
    input  logic [brf_pkg::BYTE_W-1:0]  write_byte,
    input  logic [brf_pkg::LEN_W-1:0]   run_length,
    input  logic [brf_pkg::OFF_W-1:0]   peek_offset,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [brf_pkg::BYTE_W-1:0]  out_byte,
    output logic [brf_pkg::STAT_W-1:0]  status,
    output logic [brf_pkg::HELD_W-1:0]  held_count,
    output logic                        last
);

    localparam int PW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > brf_pkg::HELD_W) ? CW : brf_pkg::HELD_W;
    localparam int AW   = ((PW > brf_pkg::OFF_W) ? PW : brf_pkg::OFF_W) + 1;
    localparam int LW   = brf_pkg::LEN_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_RREQ  = 2'd2;
    localparam logic [1:0] S_RDATA = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [PW-1:0] wp_reg, wp_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] addr_reg, addr_next;
    logic [LW-1:0] remain_reg, remain_next;

    brf_pkg::mode_t              mode_reg;
    logic [brf_pkg::BYTE_W-1:0]  wbyte_reg;
    logic [LW-1:0]               len_reg;
    logic [brf_pkg::OFF_W-1:0]   off_reg;

    logic                        out_valid_reg;
    logic [brf_pkg::BYTE_W-1:0]  out_byte_reg;
    brf_pkg::stat_t              out_stat_reg;
    logic [brf_pkg::HELD_W-1:0]  out_held_reg;
    logic                        out_last_reg;

    logic                        in_accept;
    logic                        out_free;
    logic [LW-1:0]               len_sat;
    logic                        full;
    logic                        read_short;
    logic                        peek_short;
    logic [CMPW-1:0]             peek_need;
    logic [AW-1:0]               peek_sum;
    logic [PW-1:0]               peek_start;

    logic                        ram_we;
    logic                        ram_re;
    logic [brf_pkg::BYTE_W-1:0]  ram_rdata;

    logic                        load;
    logic [brf_pkg::BYTE_W-1:0]  o_byte;
    brf_pkg::stat_t              o_stat;
    logic [CW-1:0]               o_held;
    logic                        o_last;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PW'(1);
        end
        return r;
    endfunction

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign len_sat = (run_length > LW'(MAX_RUN)) ? LW'(MAX_RUN) : run_length;

    assign full       = (count_reg == CW'(DEPTH));
    assign read_short = (CMPW'(count_reg) < CMPW'(len_reg));
    assign peek_need  = CMPW'(len_reg) + CMPW'(off_reg);
    assign peek_short = (CMPW'(count_reg) < peek_need);

    // offset is below depth whenever a peek of nonzero length passes its check
    assign peek_sum   = AW'(rp_reg) + AW'(off_reg);
    assign peek_start = (peek_sum >= AW'(DEPTH)) ? PW'(peek_sum - AW'(DEPTH))
                                                 : PW'(peek_sum);

    brf_ram #(
        .WIDTH (brf_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (wbyte_reg),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        rp_next     = rp_reg;
        wp_next     = wp_reg;
        count_next  = count_reg;
        addr_next   = addr_reg;
        remain_next = remain_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        load        = 1'b0;
        o_byte      = '0;
        o_stat      = brf_pkg::STAT_OK;
        o_held      = count_reg;
        o_last      = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (out_free)
                begin
                    case (mode_reg)
                        brf_pkg::MODE_WRITE:
                        begin
                            load = 1'b1;
                            if (full)
                            begin
                                o_stat = brf_pkg::STAT_OVERFLOW;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                wp_next    = ptr_inc(wp_reg);
                                count_next = count_reg + CW'(1);
                                o_held     = count_reg + CW'(1);
                            end
                        end

                        brf_pkg::MODE_READ:
                        begin
                            if (read_short)
                            begin
                                load   = 1'b1;
                                o_stat = brf_pkg::STAT_NOT_ENOUGH;
                            end
                            else if (len_reg == '0)
                            begin
                                load = 1'b1;
                            end
                            else
                            begin
                                addr_next   = rp_reg;
                                remain_next = len_reg;
                                state_next  = S_RREQ;
                            end
                        end

                        brf_pkg::MODE_PEEK:
                        begin
                            if (peek_short)
                            begin
                                load   = 1'b1;
                                o_stat = brf_pkg::STAT_PEEK_RANGE;
                            end
                            else if (len_reg == '0)
                            begin
                                load = 1'b1;
                            end
                            else
                            begin
                                addr_next   = peek_start;
                                remain_next = len_reg;
                                state_next  = S_RREQ;
                            end
                        end

                        brf_pkg::MODE_FLUSH:
                        begin
                            load       = 1'b1;
                            rp_next    = '0;
                            wp_next    = '0;
                            count_next = '0;
                            o_held     = '0;
                        end

                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                    if (load)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_RREQ:
            begin
                ram_re     = 1'b1;
                state_next = S_RDATA;
            end

            S_RDATA:
            begin
                // read data stays in the ram output register while we wait
                if (out_free)
                begin
                    load        = 1'b1;
                    o_byte      = ram_rdata;
                    o_last      = (remain_reg == LW'(1));
                    addr_next   = ptr_inc(addr_reg);
                    remain_next = remain_reg - LW'(1);
                    if (mode_reg == brf_pkg::MODE_READ)
                    begin
                        rp_next    = ptr_inc(rp_reg);
                        count_next = count_reg - CW'(1);
                        o_held     = count_reg - CW'(1);
                    end
                    state_next = o_last ? S_IDLE : S_RREQ;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rp_reg        <= '0;
            wp_reg        <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rp_reg    <= rp_next;
            wp_reg    <= wp_next;
            count_reg <= count_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        remain_reg <= remain_next;
        if (in_accept)
        begin
            mode_reg  <= mode;
            wbyte_reg <= write_byte;
            len_reg   <= len_sat;
            off_reg   <= peek_offset;
        end
        if (load)
        begin
            out_byte_reg <= o_byte;
            out_stat_reg <= o_stat;
            out_held_reg <= brf_pkg::HELD_W'(o_held);
            out_last_reg <= o_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign status     = out_stat_reg;
    assign held_count = out_held_reg;
    assign last       = out_last_reg;

endmodule

[tb/sv/byte_ring_fifo_with_peek_tb.sv]
// self-checking testbench for the byte ring fifo: directed, fill-to-overflow and random traffic
module byte_ring_fifo_with_peek_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import brf_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_WAIT  = 20;
    localparam int RING_AW     = $clog2(DEPTH_DEF);

    typedef struct {
        logic [BYTE_W-1:0] data;
        stat_t             code;
        logic [HELD_W-1:0] held;
        logic              tail;
    } result_beat_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [MODE_W-1:0]   mode;
    logic [BYTE_W-1:0]   write_byte;
    logic [LEN_W-1:0]    run_length;
    logic [OFF_W-1:0]    peek_offset;
    logic                out_valid;
    logic                out_ready;
    logic [BYTE_W-1:0]   out_byte;
    logic [STAT_W-1:0]   status;
    logic [HELD_W-1:0]   held_count;
    logic                last;

    // fifo contents as the block should hold them
    logic [BYTE_W-1:0]   ring_copy [DEPTH_DEF];
    int                  ring_rd;
    int                  ring_wr;
    int                  ring_fill;

    result_beat_t        pending_beats [$];
    int                  errors;
    int                  cmds_sent;
    int                  cycles;
    int                  send_idle_pct;
    int                  recv_idle_pct;

    byte_ring_fifo_with_peek i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .write_byte  (write_byte),
        .run_length  (run_length),
        .peek_offset (peek_offset),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .status      (status),
        .held_count  (held_count),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // receiver back-pressure
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic void expect_beat(logic [BYTE_W-1:0] data, stat_t code, int held,
                                        logic tail);
        result_beat_t b;
        b.data = data;
        b.code = code;
        b.held = HELD_W'(held);
        b.tail = tail;
        pending_beats.push_back(b);
    endfunction

    function automatic void predict_fifo_cmd(mode_t m, logic [BYTE_W-1:0] wb,
                                             logic [LEN_W-1:0] len_in,
                                             logic [OFF_W-1:0] off);
        int n;
        n = (len_in > MAX_RUN_DEF) ? MAX_RUN_DEF : int'(len_in);
        case (m)
            MODE_WRITE:
            begin
                if (ring_fill >= DEPTH_DEF)
                begin
                    expect_beat('0, STAT_OVERFLOW, ring_fill, 1'b1);
                end
                else
                begin
                    ring_copy[ring_wr[RING_AW-1:0]] = wb;
                    ring_wr = (ring_wr + 1) % DEPTH_DEF;
                    ring_fill++;
                    expect_beat('0, STAT_OK, ring_fill, 1'b1);
                end
            end
            MODE_READ:
            begin
                if (ring_fill < n)
                begin
                    expect_beat('0, STAT_NOT_ENOUGH, ring_fill, 1'b1);
                end
                else if (n == 0)
                begin
                    expect_beat('0, STAT_OK, ring_fill, 1'b1);
                end
                else
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        ring_fill--;
                        expect_beat(ring_copy[ring_rd[RING_AW-1:0]], STAT_OK, ring_fill,
                                    i == n - 1);
                        ring_rd = (ring_rd + 1) % DEPTH_DEF;
                    end
                end
            end
            MODE_PEEK:
            begin
                if (ring_fill < n + int'(off))
                begin
                    expect_beat('0, STAT_PEEK_RANGE, ring_fill, 1'b1);
                end
                else if (n == 0)
                begin
                    expect_beat('0, STAT_OK, ring_fill, 1'b1);
                end
                else
                begin
                    // positions wrap round the ring
                    for (int i = 0; i < n; i++)
                    begin
                        expect_beat(ring_copy[RING_AW'((ring_rd + int'(off) + i) % DEPTH_DEF)],
                                    STAT_OK, ring_fill, i == n - 1);
                    end
                end
            end
            MODE_FLUSH:
            begin
                ring_rd = 0;
                ring_wr = 0;
                ring_fill = 0;
                expect_beat('0, STAT_OK, 0, 1'b1);
            end
            default:
            begin
                expect_beat('0, STAT_OK, ring_fill, 1'b1);
            end
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin
        result_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_beats.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat, expected none, got byte %02h status %0d",
                         $time, out_byte, status);
            end
            else
            begin
                want = pending_beats.pop_front();
                if (out_byte !== want.data || status !== want.code ||
                    held_count !== want.held || last !== want.tail)
                begin
                    errors++;
                    if (out_byte !== want.data)
                        $display("%0t: out_byte mismatch, expected %02h, got %02h",
                                 $time, want.data, out_byte);
                    if (status !== want.code)
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.code, status);
                    if (held_count !== want.held)
                        $display("%0t: held_count mismatch, expected %0d, got %0d",
                                 $time, want.held, held_count);
                    if (last !== want.tail)
                        $display("%0t: last mismatch, expected %0b, got %0b",
                                 $time, want.tail, last);
                end
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_cmd(mode_t m, logic [BYTE_W-1:0] wb, logic [LEN_W-1:0] len,
                            logic [OFF_W-1:0] off);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        write_byte  <= wb;
        run_length  <= len;
        peek_offset <= off;
        do
            @(posedge clk);
        while (!in_ready);
        predict_fifo_cmd(m, wb, len, off);
        cmds_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_beats.size() != 0);
    endtask

    task automatic test_empty_fifo();
        send_cmd(MODE_STATUS, '0, '0, '0);
        send_cmd(MODE_READ, '0, 7'd1, '0);
        send_cmd(MODE_READ, '0, 7'd0, '0);
        send_cmd(MODE_PEEK, '0, 7'd0, '0);
        send_cmd(MODE_PEEK, '0, 7'd1, '0);
        for (int m = MODE_STATUS + 1; m < (1 << MODE_W); m++)
            send_cmd(mode_t'(m), '0, '0, '0);
        send_cmd(MODE_FLUSH, '0, '0, '0);
    endtask

    task automatic test_byte_runs();
        send_cmd(MODE_WRITE, 8'h00, '0, '0);
        send_cmd(MODE_WRITE, 8'hff, '0, '0);
        send_cmd(MODE_WRITE, 8'ha5, '0, '0);
        send_cmd(MODE_WRITE, 8'h5a, '0, '0);
        send_cmd(MODE_PEEK, '0, 7'd2, 10'd1);
        send_cmd(MODE_PEEK, '0, 7'd4, 10'd1023);
        // saturates to the longest run, still more than held
        send_cmd(MODE_READ, '0, 7'd127, '0);
        send_cmd(MODE_READ, '0, 7'd3, '0);
        send_cmd(MODE_STATUS, '0, '0, '0);
        send_cmd(MODE_FLUSH, '0, '0, '0);
        send_cmd(MODE_WRITE, 8'h3c, '0, '0);
        send_cmd(MODE_READ, '0, 7'd1, '0);
    endtask

    task automatic test_fill_overflow();
        send_cmd(MODE_FLUSH, '0, '0, '0);
        repeat (DEPTH_DEF)
            send_cmd(MODE_WRITE, BYTE_W'($urandom), '0, '0);
        repeat (3)
            send_cmd(MODE_WRITE, BYTE_W'($urandom), '0, '0);
        send_cmd(MODE_PEEK, '0, 7'd127, 10'd0);
        send_cmd(MODE_PEEK, '0, 7'd64, 10'd960);
        send_cmd(MODE_PEEK, '0, 7'd64, 10'd961);
        send_cmd(MODE_READ, '0, 7'd127, '0);
        // refilling puts bytes at the start of the ring, so the held data wraps round its end
        repeat (MAX_RUN_DEF)
            send_cmd(MODE_WRITE, BYTE_W'($urandom), '0, '0);
        send_cmd(MODE_WRITE, BYTE_W'($urandom), '0, '0);
        send_cmd(MODE_PEEK, '0, 7'd24, 10'd1000);
        send_cmd(MODE_READ, '0, 7'd64, '0);
        wait_drained();
        send_cmd(MODE_READ, '0, 7'd64, '0);
        send_cmd(MODE_STATUS, '0, '0, '0);
    endtask

    task automatic test_random_traffic(int n_items);
        int start;
        int pick;
        int cap;
        int len;
        start = cmds_sent;
        while (cmds_sent - start < n_items)
        begin
            pick = $urandom_range(99);
            cap = (ring_fill < MAX_RUN_DEF) ? ring_fill : MAX_RUN_DEF;
            if (pick < 45)
            begin
                repeat ($urandom_range(1, 16))
                    send_cmd(MODE_WRITE, BYTE_W'($urandom), LEN_W'($urandom),
                             OFF_W'($urandom));
            end
            else if (pick < 65)
            begin
                if (cap > 0 && $urandom_range(99) < 85)
                    len = $urandom_range(1, cap);
                else
                    len = $urandom_range((1 << LEN_W) - 1);
                send_cmd(MODE_READ, BYTE_W'($urandom), LEN_W'(len), OFF_W'($urandom));
            end
            else if (pick < 85)
            begin
                if (cap > 0 && $urandom_range(99) < 85)
                begin
                    len = $urandom_range(1, cap);
                    send_cmd(MODE_PEEK, BYTE_W'($urandom), LEN_W'(len),
                             OFF_W'($urandom_range(0, ring_fill - len)));
                end
                else
                    send_cmd(MODE_PEEK, BYTE_W'($urandom), LEN_W'($urandom),
                             OFF_W'($urandom));
            end
            else if (pick < 87)
                send_cmd(MODE_FLUSH, BYTE_W'($urandom), LEN_W'($urandom), OFF_W'($urandom));
            else if (pick < 91)
                send_cmd(MODE_STATUS, BYTE_W'($urandom), LEN_W'($urandom), OFF_W'($urandom));
            else if (pick < 93)
                wait_drained();
            else
                send_cmd(mode_t'($urandom_range((1 << MODE_W) - 1)), BYTE_W'($urandom),
                         LEN_W'($urandom), OFF_W'($urandom));
        end
    endtask

    initial
    begin
        errors        = 0;
        cmds_sent     = 0;
        ring_rd       = 0;
        ring_wr       = 0;
        ring_fill     = 0;
        send_idle_pct = 36;
        recv_idle_pct = 73;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        mode          = MODE_WRITE;
        write_byte    = '0;
        run_length    = '0;
        peek_offset   = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_fifo();
        test_byte_runs();
        test_fill_overflow();
        test_random_traffic(150);

        send_idle_pct = 73;
        recv_idle_pct = 36;
        test_random_traffic(155);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(155);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
